// ===== hw/rtl/keyword_identifier_string_lexer_defines.svh =====
// Assertion macros shared by the checkers of the keyword, identifier and string lexer.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef KEYWORD_IDENTIFIER_STRING_LEXER_DEFINES_SVH
`define KEYWORD_IDENTIFIER_STRING_LEXER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KISL_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KISL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/kisl_pkg.sv =====
// Package for the keyword, identifier and string lexer.
// Holds the scanner mode type, token kind codes and the result word types.
// No dependencies.
package kisl_pkg;

	// Scanner mode between program bytes.
	typedef enum logic [3:0] {
		MODE_IDLE,
		MODE_SLASH,
		MODE_COMMENT,
		MODE_STRING,
		MODE_IDENT,
		MODE_KW_FUN,
		MODE_KW_UNIT,
		MODE_KW_INT,
		MODE_KW_BYTE
	} lex_mode_t;

	// Token kind codes.
	localparam logic [3:0] KIND_FUN    = 4'd0;
	localparam logic [3:0] KIND_UNIT   = 4'd1;
	localparam logic [3:0] KIND_INT    = 4'd2;
	localparam logic [3:0] KIND_BYTE   = 4'd3;
	localparam logic [3:0] KIND_STAR   = 4'd4;
	localparam logic [3:0] KIND_LPAREN = 4'd5;
	localparam logic [3:0] KIND_RPAREN = 4'd6;
	localparam logic [3:0] KIND_LBRACE = 4'd7;
	localparam logic [3:0] KIND_RBRACE = 4'd8;
	localparam logic [3:0] KIND_COMMA  = 4'd9;
	localparam logic [3:0] KIND_COLON  = 4'd10;
	localparam logic [3:0] KIND_SEMI   = 4'd11;
	localparam logic [3:0] KIND_EQUALS = 4'd12;
	localparam logic [3:0] KIND_IDENT  = 4'd13;
	localparam logic [3:0] KIND_STRING = 4'd14;

	// One byte can cause at most three result words.
	localparam int RES_MAX = 3;

	// One result word.
	typedef struct packed {
		logic [3:0]  token_kind;
		logic [15:0] start_pos;
		logic [16:0] end_pos;
		logic [15:0] line_no;
		logic [15:0] column_no;
		logic        is_error;
		logic        last_result;
	} kisl_result_t;

	// Result words produced by one lexing step, in order, count of them valid.
	typedef struct packed {
		kisl_result_t [RES_MAX-1:0] res;
		logic [1:0]                 count;
	} kisl_push_t;

endpackage

// ===== hw/rtl/kisl_lexer.sv =====
// Lexing step of the keyword, identifier and string lexer: scanner state registers
// and the combinational next-state and result logic. Depends on kisl_pkg.
module kisl_lexer
	import kisl_pkg::*;
#(
	parameter int MAX_PROGRAM_BYTES = 65536
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  logic [7:0] ch,
	input  logic       end_of_program,
	output kisl_push_t push
);

	localparam int POS_W = $clog2(MAX_PROGRAM_BYTES + 1);
	localparam int EXT_W = (POS_W > 17) ? POS_W : 17;
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_PROGRAM_BYTES);

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SLASH   = "/";
	localparam logic [7:0] CH_QUOTE   = 8'h22;

	typedef struct packed {
		lex_mode_t    mode;
		logic [2:0]   pend;
		logic [15:0]  tok_pos;
		logic [15:0]  tok_line;
		logic [15:0]  tok_col;
		logic         err;
		logic         hold_v;
		kisl_result_t hold;
	} lex_state_t;

	typedef struct packed {
		lex_state_t st;
		kisl_push_t out;
	} lex_step_t;

	lex_state_t       state_q;
	lex_state_t       state_d;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_d;
	logic [POS_W-1:0] pos_inc;
	logic [15:0]      line_q;
	logic [15:0]      line_d;
	logic [15:0]      col_q;
	logic [15:0]      col_d;
	logic [EXT_W-1:0] pos_ext;
	logic [EXT_W-1:0] pos_inc_ext;
	logic [16:0]      pos17;
	logic [16:0]      pos_inc17;
	logic [1:0]       kidx;
	logic             fall;
	lex_step_t        s;

	// Character classes.
	function automatic logic is_alpha(logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic is_alnum(logic [7:0] c);
		return is_alpha(c) || ((c >= "0") && (c <= "9"));
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return (c == " ") || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	function automatic logic is_punct(logic [7:0] c);
		return (c == "*") || (c == "(") || (c == ")") || (c == "{") || (c == "}") ||
			(c == ",") || (c == ":") || (c == ";") || (c == "=");
	endfunction

	function automatic logic [3:0] punct_kind(logic [7:0] c);
		logic [3:0] k;
		case (c)
			"*": k = KIND_STAR;
			"(": k = KIND_LPAREN;
			")": k = KIND_RPAREN;
			"{": k = KIND_LBRACE;
			"}": k = KIND_RBRACE;
			",": k = KIND_COMMA;
			":": k = KIND_COLON;
			";": k = KIND_SEMI;
			default: k = KIND_EQUALS;
		endcase
		return k;
	endfunction

	// Keyword spelling: keyword index in the upper bits, character index in the lower.
	function automatic logic [7:0] kw_char(logic [1:0] k, logic [1:0] idx);
		logic [7:0] c;
		case ({k, idx})
			4'b0000: c = "f";
			4'b0001: c = "u";
			4'b0010: c = "n";
			4'b0100: c = "u";
			4'b0101: c = "n";
			4'b0110: c = "i";
			4'b0111: c = "t";
			4'b1000: c = "i";
			4'b1001: c = "n";
			4'b1010: c = "t";
			4'b1100: c = "b";
			4'b1101: c = "y";
			4'b1110: c = "t";
			4'b1111: c = "e";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] kw_len(logic [1:0] k);
		return ((k == KIND_FUN[1:0]) || (k == KIND_INT[1:0])) ? 3'd3 : 3'd4;
	endfunction

	function automatic logic [15:0] sat_inc(logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	// Append one result word to the step's output list.
	function automatic lex_step_t emit(lex_step_t sv, kisl_result_t r);
		lex_step_t t;
		t = sv;
		t.out.res[t.out.count] = r;
		t.out.count = t.out.count + 2'd1;
		return t;
	endfunction

	function automatic kisl_result_t make_tok(logic [3:0] kind, logic [15:0] sp,
			logic [16:0] ep, logic [15:0] ln, logic [15:0] cn);
		kisl_result_t r;
		r.token_kind  = kind;
		r.start_pos   = sp;
		r.end_pos     = ep;
		r.line_no     = ln;
		r.column_no   = cn;
		r.is_error    = 1'b0;
		r.last_result = 1'b0;
		return r;
	endfunction

	// A finished token replaces the held one, which goes out first.
	function automatic lex_step_t push_tok(lex_step_t sv, kisl_result_t r);
		lex_step_t t;
		t = sv;
		if (t.st.hold_v) begin
			t = emit(t, t.st.hold);
		end
		t.st.hold_v = 1'b1;
		t.st.hold = r;
		return t;
	endfunction

	// Error: flush the held token, send the error word, ignore the rest of the program.
	function automatic lex_step_t fail(lex_step_t sv, logic [15:0] ln, logic [15:0] cn);
		lex_step_t    t;
		kisl_result_t r;
		t = sv;
		if (t.st.hold_v) begin
			t = emit(t, t.st.hold);
		end
		t.st.hold_v = 1'b0;
		r = make_tok(KIND_FUN, 16'd0, 17'd0, ln, cn);
		r.is_error = 1'b1;
		r.last_result = 1'b1;
		t = emit(t, r);
		t.st.err = 1'b1;
		t.st.mode = MODE_IDLE;
		return t;
	endfunction

	assign pos_inc     = pos_q + 1'b1;
	assign pos_ext     = EXT_W'(pos_q);
	assign pos_inc_ext = EXT_W'(pos_inc);
	assign pos17       = pos_ext[16:0];
	assign pos_inc17   = pos_inc_ext[16:0];
	assign kidx        = 2'(state_q.mode - MODE_KW_FUN);

	// Next scanner state and the result words of the byte in the input register.
	always_comb begin
		s = '0;
		s.st = state_q;
		pos_d = pos_q;
		line_d = line_q;
		col_d = col_q;
		fall = 1'b0;
		if (step_en && !state_q.err) begin
			if (pos_q == POS_LIMIT) begin
				s = fail(s, line_q, col_q);
			end else begin
				case (state_q.mode)
					MODE_IDLE: begin
						fall = 1'b1;
					end
					MODE_SLASH: begin
						if (ch == CH_SLASH) begin
							s.st.mode = MODE_COMMENT;
						end else begin
							s = fail(s, state_q.tok_line, state_q.tok_col);
						end
					end
					MODE_COMMENT: begin
						if (ch == CH_NEWLINE) begin
							s.st.mode = MODE_IDLE;
						end
					end
					MODE_STRING: begin
						if (ch == CH_QUOTE) begin
							s = push_tok(s, make_tok(KIND_STRING, state_q.tok_pos + 16'd1, pos17,
								state_q.tok_line, sat_inc(state_q.tok_col)));
							s.st.mode = MODE_IDLE;
						end else if (ch == CH_NEWLINE) begin
							s = fail(s, state_q.tok_line, state_q.tok_col);
						end
					end
					MODE_IDENT: begin
						if (!is_alnum(ch)) begin
							s = push_tok(s, make_tok(KIND_IDENT, state_q.tok_pos, pos17,
								state_q.tok_line, state_q.tok_col));
							s.st.mode = MODE_IDLE;
							fall = 1'b1;
						end
					end
					MODE_KW_FUN, MODE_KW_UNIT, MODE_KW_INT, MODE_KW_BYTE: begin
						if (ch == kw_char(kidx, state_q.pend[1:0])) begin
							s.st.pend = state_q.pend + 3'd1;
							if (s.st.pend >= kw_len(kidx)) begin
								s = push_tok(s, make_tok({2'b00, kidx}, state_q.tok_pos, pos_inc17,
									state_q.tok_line, state_q.tok_col));
								s.st.pend = 3'd0;
								s.st.mode = MODE_IDLE;
							end
						end else begin
							// Keyword prefix broken: the token continues as an identifier.
							s.st.pend = 3'd0;
							s.st.mode = MODE_IDENT;
							if (!is_alnum(ch)) begin
								s = push_tok(s, make_tok(KIND_IDENT, state_q.tok_pos, pos17,
									state_q.tok_line, state_q.tok_col));
								s.st.mode = MODE_IDLE;
								fall = 1'b1;
							end
						end
					end
					default: begin
						s.st.mode = MODE_IDLE;
						fall = 1'b1;
					end
				endcase

				// Byte at a token boundary: start a new token or report it.
				if (fall) begin
					if (is_space(ch)) begin
						s.st.mode = MODE_IDLE;
					end else if ((ch == CH_SLASH) || (ch == CH_QUOTE) || is_alpha(ch)) begin
						s.st.tok_pos = pos17[15:0];
						s.st.tok_line = line_q;
						s.st.tok_col = col_q;
						if (ch == CH_SLASH) begin
							s.st.mode = MODE_SLASH;
						end else if (ch == CH_QUOTE) begin
							s.st.mode = MODE_STRING;
						end else if (ch == "f") begin
							s.st.pend = 3'd1;
							s.st.mode = MODE_KW_FUN;
						end else if (ch == "u") begin
							s.st.pend = 3'd1;
							s.st.mode = MODE_KW_UNIT;
						end else if (ch == "i") begin
							s.st.pend = 3'd1;
							s.st.mode = MODE_KW_INT;
						end else if (ch == "b") begin
							s.st.pend = 3'd1;
							s.st.mode = MODE_KW_BYTE;
						end else begin
							s.st.mode = MODE_IDENT;
						end
					end else if (is_punct(ch)) begin
						s = push_tok(s, make_tok(punct_kind(ch), pos17[15:0], pos_inc17,
							line_q, col_q));
					end else begin
						s = fail(s, line_q, col_q);
					end
				end

				// Position, line and column advance past this byte.
				pos_d = pos_inc;
				if (ch == CH_NEWLINE) begin
					line_d = sat_inc(line_q);
					col_d = 16'd1;
				end else begin
					col_d = sat_inc(col_q);
				end
			end

			// Program end: close or fail an open token, then release the held one as last.
			if (end_of_program && !s.st.err) begin
				if ((s.st.mode == MODE_IDENT) || (s.st.mode == MODE_KW_FUN) ||
						(s.st.mode == MODE_KW_UNIT) || (s.st.mode == MODE_KW_INT) ||
						(s.st.mode == MODE_KW_BYTE)) begin
					s = push_tok(s, make_tok(KIND_IDENT, s.st.tok_pos, pos_inc17,
						s.st.tok_line, s.st.tok_col));
				end else if ((s.st.mode == MODE_SLASH) || (s.st.mode == MODE_STRING)) begin
					s = fail(s, s.st.tok_line, s.st.tok_col);
				end
				if (!s.st.err && s.st.hold_v) begin
					s.st.hold.last_result = 1'b1;
					s = emit(s, s.st.hold);
					s.st.hold_v = 1'b0;
				end
			end
		end

		// Every program starts from the reset state.
		if (step_en && end_of_program) begin
			s.st.mode = MODE_IDLE;
			s.st.pend = 3'd0;
			s.st.tok_pos = 16'd0;
			s.st.tok_line = 16'd1;
			s.st.tok_col = 16'd1;
			s.st.err = 1'b0;
			s.st.hold_v = 1'b0;
			pos_d = '0;
			line_d = 16'd1;
			col_d = 16'd1;
		end
		state_d = s.st;
		push = s.out;
	end

	// Scanner state registers, held token included.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode <= MODE_IDLE;
			state_q.pend <= 3'd0;
			state_q.tok_pos <= 16'd0;
			state_q.tok_line <= 16'd1;
			state_q.tok_col <= 16'd1;
			state_q.err <= 1'b0;
			state_q.hold_v <= 1'b0;
			state_q.hold <= '0;
			pos_q <= '0;
			line_q <= 16'd1;
			col_q <= 16'd1;
		end else begin
			state_q.mode <= state_d.mode;
			state_q.pend <= state_d.pend;
			state_q.tok_pos <= state_d.tok_pos;
			state_q.tok_line <= state_d.tok_line;
			state_q.tok_col <= state_d.tok_col;
			state_q.err <= state_d.err;
			state_q.hold_v <= state_d.hold_v;
			state_q.hold <= state_d.hold;
			pos_q <= pos_d;
			line_q <= line_d;
			col_q <= col_d;
		end
	end

endmodule

// ===== hw/rtl/kisl_result_fifo.sv =====
// Result queue of the keyword, identifier and string lexer: takes up to three words
// per cycle from the lexing step, hands out one a cycle on pop. Depends on kisl_pkg.
module kisl_result_fifo
	import kisl_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  kisl_push_t   push,
	input  logic         pop,
	output kisl_result_t head,
	output logic         head_valid,
	output logic         room
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	kisl_result_t     entry_q [DEPTH];
	logic [PTR_W-1:0] slot_off [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// Distance of each entry from the write pointer picks the word it takes.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			slot_off[i] = PTR_W'(i) - wr_ptr_q;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (CNT_W'(slot_off[i]) < CNT_W'(push.count)) begin
				entry_q[i] <= push.res[slot_off[i]];
			end
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

	assign head       = entry_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	// Room for a whole step's worth of words, decided from registered state only.
	assign room       = (count_q <= CNT_W'(DEPTH - RES_MAX));

endmodule

// ===== hw/rtl/keyword_identifier_string_lexer.sv =====
// Keyword, identifier and string lexer, top level.
// Uses kisl_pkg, kisl_lexer and kisl_result_fifo.
//
// The slave stream carries one program byte per word; tlast marks the final byte of a
// program. The master stream carries one result word per token or error; tlast is set
// on the final result of a program, and an error result always carries it.
// Each finished token is held back until the next token, error or program end, so a
// token's word appears only when one of those comes. From the acceptance of the
// byte that releases a word, the word passes the input register and then the result
// queue before it is on the master side.
// Throughput is one byte per cycle. A byte can cause up to three result words; the
// four-word result queue and the one-word-per-cycle master side set the rate when a
// run of bytes yields more words than that, and the slave side then stalls.
// When the receiver stalls, the queue fills and tready on the slave side drops until
// there is room for a full step again; nothing is lost.
// Reset clears the scanner to the start of a program at line 1, column 1, and empties
// the queue. A byte arriving at offset MAX_PROGRAM_BYTES is reported as an error.
module keyword_identifier_string_lexer
	import kisl_pkg::*;
#(
	parameter int MAX_PROGRAM_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] ch
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // [15:0] start_pos, [32:16] end_pos,
	                                   // [48:33] line_no, [64:49] column_no, [71:65] zero
	output logic [4:0]  m_axis_tuser,  // [3:0] token_kind, [4] is_error
	output logic        m_axis_tlast
);

	logic         valid_s1;
	logic [7:0]   ch_s1;
	logic         eop_s1;
	logic         room;
	logic         step_fire;
	logic         in_fire;
	logic         pop;
	kisl_push_t   push;
	kisl_result_t head;

	assign step_fire     = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// Input register: holds the byte until the queue can take its results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (step_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ch_s1 <= s_axis_tdata;
			eop_s1 <= s_axis_tlast;
		end
	end

	kisl_lexer #(
		.MAX_PROGRAM_BYTES(MAX_PROGRAM_BYTES)
	) u_lexer (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (step_fire),
		.ch            (ch_s1),
		.end_of_program(eop_s1),
		.push          (push)
	);

	kisl_result_fifo u_result_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.head      (head),
		.head_valid(m_axis_tvalid),
		.room      (room)
	);

	// Master side word.
	assign pop          = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata = {7'd0, head.column_no, head.line_no, head.end_pos, head.start_pos};
	assign m_axis_tuser = {head.is_error, head.token_kind};
	assign m_axis_tlast = head.last_result;

endmodule

// ===== hw/rtl/kisl_checker.sv =====
// Port-level checks for the keyword, identifier and string lexer, bound to its top level.
// Depends on keyword_identifier_string_lexer_defines.svh.
`include "keyword_identifier_string_lexer_defines.svh"

module kisl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata,
	input logic [4:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// A stalled result word stays in place.
	`KISL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result word changed while stalled")

	// An error word has no token fields and ends the program.
	`KISL_ASSERT_SAME(a_err_word, m_axis_tvalid && m_axis_tuser[4], m_axis_tuser[3:0] == 4'd0 && m_axis_tdata[32:0] == 33'd0 && m_axis_tlast, "malformed error word")

	// Lines and columns count from one.
	`KISL_ASSERT_SAME(a_line_col, m_axis_tvalid, m_axis_tdata[48:33] != 16'd0 && m_axis_tdata[64:49] != 16'd0, "line or column is zero")

	// Kind fifteen is never produced.
	`KISL_ASSERT_SAME(a_kind_range, m_axis_tvalid, m_axis_tuser[3:0] != 4'd15, "token kind out of range")

endmodule

bind keyword_identifier_string_lexer kisl_checker u_kisl_checker (.*);

// ===== tb/tb_keyword_identifier_string_lexer.sv =====
// Self-checking testbench for the keyword, identifier and string lexer.
// Drives program bytes, predicts every result word and compares them at the master side.
// Depends on kisl_pkg and keyword_identifier_string_lexer.
module tb_keyword_identifier_string_lexer;
	import kisl_pkg::*;

	localparam int PROG_LIMIT = 65536;
	localparam int CYCLE_LIMIT = 1000000;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LOW_A = 8'h61;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] ch
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;          // [15:0] start_pos, [32:16] end_pos,
	                                    // [48:33] line_no, [64:49] column_no
	logic [4:0]  m_axis_tuser;          // [3:0] token_kind, [4] is_error
	logic        m_axis_tlast;

	keyword_identifier_string_lexer #(
		.MAX_PROGRAM_BYTES(PROG_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #1 clk = ~clk;

	// Keyword spellings, in the order of their token kinds.
	string      kw_word [4] = '{"fun", "unit", "int", "byte"};
	string      punct_chars = "*(){},:;=";
	logic [7:0] space_chars [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

	// Idle percentages for the two sides.
	int send_gap_pct = 0;
	int recv_stall_pct = 0;

	int mismatches = 0;
	int bytes_sent = 0;
	int programs_sent = 0;
	int words_seen = 0;
	int error_words_seen = 0;
	int cycle_count = 0;

	// Scanner copy used for prediction.
	lex_mode_t    scan_state;
	logic [16:0]  scan_pos;
	logic [15:0]  scan_line;
	logic [15:0]  scan_col;
	int           kw_seen;
	logic [15:0]  tok_pos;
	logic [15:0]  tok_line;
	logic [15:0]  tok_col;
	bit           prog_failed;
	bit           held_valid;
	kisl_result_t held_word;

	// Result words still owed by the block, oldest first.
	kisl_result_t expected_words [$];

	// Program text waiting to be sent.
	logic [7:0] prog_text [$];

	// Queue helpers: add at the tail.
	function void expect_word(input kisl_result_t w);
		expected_words.insert(expected_words.size(), w);
	endfunction

	function void add_char(input logic [7:0] c);
		prog_text.insert(prog_text.size(), c);
	endfunction

	function automatic logic [15:0] sat_up(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_alnum(input logic [7:0] c);
		return is_letter(c) || (c >= "0" && c <= "9");
	endfunction

	function automatic bit is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function void clear_scanner();
		scan_state = MODE_IDLE;
		scan_pos = '0;
		scan_line = 16'd1;
		scan_col = 16'd1;
		kw_seen = 0;
		tok_pos = '0;
		tok_line = 16'd1;
		tok_col = 16'd1;
		prog_failed = 1'b0;
		held_valid = 1'b0;
	endfunction

	// A finished token is held until the next token, error or program end, so the final one can carry tlast.
	function void hold_token(input logic [3:0] kind, input logic [15:0] s,
		input logic [16:0] e, input logic [15:0] l, input logic [15:0] c);
		if (held_valid)
			expect_word(held_word);
		held_word = '{token_kind: kind, start_pos: s, end_pos: e, line_no: l,
			column_no: c, is_error: 1'b0, last_result: 1'b0};
		held_valid = 1'b1;
	endfunction

	function void hold_ident();
		hold_token(KIND_IDENT, tok_pos, scan_pos, tok_line, tok_col);
	endfunction

	function void report_fault(input logic [15:0] l, input logic [15:0] c);
		kisl_result_t err_word;
		if (held_valid)
			expect_word(held_word);
		held_valid = 1'b0;
		err_word = '{token_kind: '0, start_pos: '0, end_pos: '0, line_no: l,
			column_no: c, is_error: 1'b1, last_result: 1'b1};
		expect_word(err_word);
		prog_failed = 1'b1;
		scan_state = MODE_IDLE;
	endfunction

	function void note_start();
		tok_pos = scan_pos[15:0];
		tok_line = scan_line;
		tok_col = scan_col;
	endfunction

	// Advances the scanner by one byte, queuing whatever words it finishes.
	function automatic void lex_char(input logic [7:0] c);
		int k;
		case (scan_state)
			MODE_IDLE: ;
			MODE_SLASH: begin
				if (c == CH_SLASH)
					scan_state = MODE_COMMENT;
				else
					report_fault(tok_line, tok_col);
				return;
			end
			MODE_COMMENT: begin
				if (c == CH_LF)
					scan_state = MODE_IDLE;
				return;
			end
			MODE_STRING: begin
				if (c == CH_QUOTE) begin
					hold_token(KIND_STRING, tok_pos + 16'd1, scan_pos, tok_line,
						sat_up(tok_col));
					scan_state = MODE_IDLE;
				end else if (c == CH_LF) begin
					report_fault(tok_line, tok_col);
				end
				return;
			end
			MODE_IDENT: begin
				if (is_alnum(c))
					return;
				hold_ident();
				scan_state = MODE_IDLE;
			end
			MODE_KW_FUN, MODE_KW_UNIT, MODE_KW_INT, MODE_KW_BYTE: begin
				k = scan_state - MODE_KW_FUN;
				if (c == kw_word[k][kw_seen]) begin
					kw_seen++;
					if (kw_seen >= kw_word[k].len()) begin
						hold_token(KIND_FUN + 4'(k), tok_pos, scan_pos + 17'd1,
							tok_line, tok_col);
						kw_seen = 0;
						scan_state = MODE_IDLE;
					end
					return;
				end
				// Mismatch turns the keyword prefix into an identifier.
				kw_seen = 0;
				scan_state = MODE_IDENT;
				if (is_alnum(c))
					return;
				hold_ident();
				scan_state = MODE_IDLE;
			end
			default: scan_state = MODE_IDLE;
		endcase

		// Start of a new token.
		if (is_space(c))
			return;
		if (c == CH_SLASH) begin
			note_start();
			scan_state = MODE_SLASH;
			return;
		end
		for (k = 0; k < 4; k++) begin
			if (c == kw_word[k][0]) begin
				note_start();
				kw_seen = 1;
				scan_state = lex_mode_t'(MODE_KW_FUN + k);
				return;
			end
		end
		if (is_letter(c)) begin
			note_start();
			scan_state = MODE_IDENT;
			return;
		end
		for (k = 0; k < punct_chars.len(); k++) begin
			if (c == punct_chars[k]) begin
				hold_token(KIND_STAR + 4'(k), scan_pos[15:0], scan_pos + 17'd1,
					scan_line, scan_col);
				return;
			end
		end
		if (c == CH_QUOTE) begin
			note_start();
			scan_state = MODE_STRING;
			return;
		end
		report_fault(scan_line, scan_col);
	endfunction

	// Closes or fails an open token at program end and releases the held word with tlast.
	function void close_program();
		if (scan_state == MODE_IDENT || scan_state >= MODE_KW_FUN)
			hold_ident();
		else if (scan_state == MODE_SLASH || scan_state == MODE_STRING)
			report_fault(tok_line, tok_col);
		if (!prog_failed && held_valid) begin
			held_word.last_result = 1'b1;
			expect_word(held_word);
			held_valid = 1'b0;
		end
	endfunction

	function void predict_byte(input logic [7:0] c, input bit eop);
		if (!prog_failed) begin
			if (scan_pos >= PROG_LIMIT) begin
				report_fault(scan_line, scan_col);
			end else begin
				lex_char(c);
				scan_pos++;
				if (c == CH_LF) begin
					scan_line = sat_up(scan_line);
					scan_col = 16'd1;
				end else begin
					scan_col = sat_up(scan_col);
				end
			end
			if (eop && !prog_failed)
				close_program();
		end
		if (eop)
			clear_scanner();
	endfunction

	function automatic logic [7:0] rand_letter();
		logic [7:0] base;
		base = $urandom_range(1) ? CH_LOW_A : 8'h41;
		return base + 8'($urandom_range(25));
	endfunction

	function automatic logic [7:0] rand_alnum();
		if ($urandom_range(3) == 0)
			return 8'h30 + 8'($urandom_range(9));
		return rand_letter();
	endfunction

	// Any byte that keeps a string or comment open.
	function automatic logic [7:0] rand_text_char();
		logic [7:0] c;
		c = 8'($urandom_range(255));
		if (c == CH_QUOTE || c == CH_LF)
			c = 8'h2E;
		return c;
	endfunction

	function void load_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i]);
	endfunction

	// Sends one byte; called just after a falling edge and returns just after one.
	task automatic send_byte(input logic [7:0] c, input bit eop);
		while ($urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= eop;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_byte(c, eop);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_program();
		for (int i = 0; i < prog_text.size(); i++)
			send_byte(prog_text[i], i == prog_text.size() - 1);
		prog_text.delete();
		programs_sent++;
	endtask

	// Every token kind in one program, an empty string, and a keyword prefix at the end.
	task automatic test_every_token();
		load_text("fununitint\"\"byte*(){},:;=b");
		send_program();
	endtask

	// Lone slash at end, comment to end, an invalid byte, broken strings, a lone space.
	task automatic test_error_cases();
		load_text("/");
		send_program();
		load_text("//");
		add_char(8'hFF);
		send_program();
		add_char(8'h80);
		send_program();
		add_char(CH_QUOTE);
		add_char(8'h00);
		add_char(CH_LF);
		send_program();
		add_char(CH_QUOTE);
		send_program();
		add_char(CH_SPACE);
		send_program();
	endtask

	// Mostly well-formed random programs; about one in four gets a piece that may break it.
	task automatic test_random_programs(input int byte_goal);
		int first_byte;
		int pieces;
		int broken_at;
		int w;
		int cut;
		first_byte = bytes_sent;
		while (bytes_sent - first_byte < byte_goal) begin
			pieces = $urandom_range(2, 8);
			broken_at = ($urandom_range(3) == 0) ? $urandom_range(pieces) : -1;
			for (int i = 0; i <= pieces; i++) begin
				if (i == broken_at) begin
					case ($urandom_range(3))
						0: begin
							add_char(CH_SLASH);
							if (i < pieces)
								add_char(rand_letter());
						end
						1: add_char(8'($urandom_range(255)));
						2: begin
							add_char(CH_QUOTE);
							add_char(rand_text_char());
							add_char(CH_LF);
						end
						default: begin
							add_char(CH_QUOTE);
							add_char(rand_letter());
						end
					endcase
				end
				if (i == pieces)
					break;
				case ($urandom_range(6))
					0: begin
						w = $urandom_range(3);
						cut = kw_word[w].len();
						if ($urandom_range(4) == 0)
							cut = $urandom_range(1, cut - 1);
						for (int j = 0; j < cut; j++)
							add_char(kw_word[w][j]);
						if ($urandom_range(3) == 0)
							add_char(rand_alnum());
					end
					1: begin
						add_char(rand_letter());
						repeat ($urandom_range(4))
							add_char(rand_alnum());
					end
					2: add_char(punct_chars[$urandom_range(8)]);
					3: begin
						add_char(CH_QUOTE);
						repeat ($urandom_range(4))
							add_char(rand_text_char());
						add_char(CH_QUOTE);
					end
					4, 5: begin
						repeat ($urandom_range(1, 3))
							add_char(space_chars[$urandom_range(5)]);
					end
					default: begin
						add_char(CH_SLASH);
						add_char(CH_SLASH);
						repeat ($urandom_range(4))
							add_char(rand_text_char());
						if ($urandom_range(3) != 0)
							add_char(CH_LF);
					end
				endcase
			end
			send_program();
		end
	endtask

	function void check_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endfunction

	// Receiver stalls.
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	// Compare every accepted result word with the oldest expectation.
	always @(posedge clk) begin
		kisl_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			words_seen++;
			if (m_axis_tuser[4])
				error_words_seen++;
			if (expected_words.size() == 0) begin
				$error("result word with no expectation waiting");
				mismatches++;
			end else begin
				want = expected_words.pop_front();
				check_field("token_kind", want.token_kind, m_axis_tuser[3:0]);
				check_field("is_error", want.is_error, m_axis_tuser[4]);
				check_field("start_pos", want.start_pos, m_axis_tdata[15:0]);
				check_field("end_pos", want.end_pos, m_axis_tdata[32:16]);
				check_field("line_no", want.line_no, m_axis_tdata[48:33]);
				check_field("column_no", want.column_no, m_axis_tdata[64:49]);
				check_field("last_result", want.last_result, m_axis_tlast);
			end
		end
	end

	// Run limit.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** keyword_identifier_string_lexer: FAILED **");
		$finish;
	end

	initial begin
		clear_scanner();
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Sender idles a little, receiver a lot.
		send_gap_pct = 15;
		recv_stall_pct = 77;
		test_every_token();
		test_error_cases();
		test_random_programs(55);

		// Sender idles a lot, receiver a little.
		send_gap_pct = 77;
		recv_stall_pct = 15;
		test_random_programs(55);

		// Full rate on both sides.
		send_gap_pct = 0;
		recv_stall_pct = 0;
		test_random_programs(55);

		s_axis_tvalid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);

		$display("Sent %0d programs, %0d bytes, under three idle patterns.",
			programs_sent, bytes_sent);
		$display("Checked %0d result words, %0d of them errors; %0d mismatches.",
			words_seen, error_words_seen, mismatches);
		if (mismatches == 0)
			$display("** keyword_identifier_string_lexer: PASSED **");
		else
			$display("** keyword_identifier_string_lexer: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/kisl_pkg.sv
hw/rtl/kisl_lexer.sv
hw/rtl/kisl_result_fifo.sv
hw/rtl/keyword_identifier_string_lexer.sv
hw/rtl/kisl_checker.sv
tb/tb_keyword_identifier_string_lexer.sv
